// ----- hdl/psgt_pkg.sv -----
package psgt_pkg;

    localparam int ADDR_W = 48;
    localparam int SEQ_W  = 16;
    localparam int GAP_W  = 15;
    localparam int SUM_W  = 32;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_REARM  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_IGNORE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] sender_addr;
        logic [SEQ_W-1:0]  seq_num;
    } t_in_item;

    typedef struct packed {
        logic              tracked;
        logic              was_baseline;
        logic [GAP_W-1:0]  gap_added;
        logic              reordered;
        logic [SUM_W-1:0]  gap_sum;
        logic [SUM_W-1:0]  reorder_sum;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  prev_seq;
        logic              needs_baseline;
    } t_entry;

endpackage

// ----- hdl/psgt_entry_ram.sv -----
module psgt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  psgt_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output psgt_pkg::t_entry o_rd_data
);
    import psgt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/peer_sequence_gap_tracker.sv -----
// per-sender sequence gap tracker
// input channel: i_in_valid / o_in_ready with i_in_item {cmd, sender_addr, seq_num}
// output channel: o_out_valid / i_out_ready with o_out_item, one result per item
// a frame or re-arm walks the slot memory one entry a cycle (one read port,
// registered read data), stopping at the first matching in-use slot, then
// does the update and loads the result register in the update step
// one item is in flight at a time; the next item is taken the cycle after the
// result is registered
// reset empties the table (in-use flags in flip-flops) and zeroes both totals;
// slot contents need no clearing as a slot is written whenever it is claimed
// a clear command drops every in-use flag at once and keeps the totals
// if the receiver stalls, the result stays in the output register; one more
// item is accepted and processed, and it waits in the update step until the
// output register is free
module peer_sequence_gap_tracker #(
    parameter int PEER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  psgt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output psgt_pkg::t_out_item o_out_item
);
    import psgt_pkg::*;

    localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PEER_SLOTS - 1);

    t_state               r_state, n_state;
    t_in_item             r_item, n_item;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_issued_all, n_issued_all;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_pidx, n_pidx;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_slot, n_slot;
    logic                 r_free_ok, n_free_ok;
    logic [IW-1:0]        r_free, n_free;
    t_entry               r_entry, n_entry;
    logic [PEER_SLOTS-1:0] r_in_use, n_in_use;
    logic [SUM_W-1:0]     r_gap_total, n_gap_total;
    logic [SUM_W-1:0]     r_reorder_total, n_reorder_total;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 rd_en;
    t_entry               rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    t_entry               wr_data;

    logic                 c_lookup;
    logic                 c_tracked;
    logic [IW-1:0]        c_slot;
    t_entry               c_ent;
    logic [SEQ_W-1:0]     c_diff;
    logic                 c_base;
    logic                 c_reord;
    logic [GAP_W-1:0]     c_gap;

    psgt_entry_ram #(
        .DEPTH(PEER_SLOTS),
        .IW   (IW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_pend          <= 1'b0;
            r_in_use        <= '0;
            r_gap_total     <= '0;
            r_reorder_total <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_pend          <= n_pend;
            r_in_use        <= n_in_use;
            r_gap_total     <= n_gap_total;
            r_reorder_total <= n_reorder_total;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_idx        <= n_idx;
        r_issued_all <= n_issued_all;
        r_pidx       <= n_pidx;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_free_ok    <= n_free_ok;
        r_free       <= n_free;
        r_entry      <= n_entry;
        r_out        <= n_out;
    end

    // update-step datapath
    always_comb begin
        c_lookup  = (r_item.cmd == CMD_FRAME) || (r_item.cmd == CMD_REARM);
        c_tracked = c_lookup && (r_hit || r_free_ok);
        c_slot    = r_hit ? r_slot : r_free;
        if (r_hit) begin
            c_ent = r_entry;
        end else begin
            c_ent.addr           = r_item.sender_addr;
            c_ent.prev_seq       = '0;
            c_ent.needs_baseline = 1'b1;
        end
        c_diff  = r_item.seq_num - c_ent.prev_seq;
        c_base  = 1'b0;
        c_reord = 1'b0;
        c_gap   = '0;
        if (c_tracked && (r_item.cmd == CMD_FRAME)) begin
            if (c_ent.needs_baseline) begin
                c_base = 1'b1;
            end else if ((c_diff == '0) || c_diff[SEQ_W-1]) begin
                c_reord = 1'b1;
            end else if (c_diff > SEQ_W'(1)) begin
                c_gap = GAP_W'(c_diff - SEQ_W'(1));
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_item          = r_item;
        n_idx           = r_idx;
        n_issued_all    = r_issued_all;
        n_pend          = r_pend;
        n_pidx          = r_pidx;
        n_hit           = r_hit;
        n_slot          = r_slot;
        n_free_ok       = r_free_ok;
        n_free          = r_free;
        n_entry         = r_entry;
        n_in_use        = r_in_use;
        n_gap_total     = r_gap_total;
        n_reorder_total = r_reorder_total;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_out           = r_out;
        o_in_ready      = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = c_slot;
        wr_data         = c_ent;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item       = i_in_item;
                    n_idx        = '0;
                    n_issued_all = 1'b0;
                    n_pend       = 1'b0;
                    n_hit        = 1'b0;
                    n_free_ok    = 1'b0;
                    if ((i_in_item.cmd == CMD_FRAME) || (i_in_item.cmd == CMD_REARM)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_UPD;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next read, compare the one issued last cycle
                n_pend = 1'b0;
                if (!r_issued_all) begin
                    rd_en        = 1'b1;
                    n_pend       = 1'b1;
                    n_pidx       = r_idx;
                    n_idx        = r_idx + IW'(1);
                    n_issued_all = (r_idx == LAST_IDX);
                end
                if (r_pend) begin
                    if (r_in_use[r_pidx] && (rd_data.addr == r_item.sender_addr)) begin
                        n_hit   = 1'b1;
                        n_slot  = r_pidx;
                        n_entry = rd_data;
                        n_pend  = 1'b0;
                        n_state = ST_UPD;
                    end else begin
                        if (!r_in_use[r_pidx] && !r_free_ok) begin
                            n_free_ok = 1'b1;
                            n_free    = r_pidx;
                        end
                        if (r_pidx == LAST_IDX) begin
                            n_pend  = 1'b0;
                            n_state = ST_UPD;
                        end
                    end
                end
            end
            ST_UPD: begin
                if (!r_out_valid || i_out_ready) begin
                    if (c_tracked) begin
                        wr_en            = 1'b1;
                        n_in_use[c_slot] = 1'b1;
                        if (r_item.cmd == CMD_FRAME) begin
                            wr_data.prev_seq       = r_item.seq_num;
                            wr_data.needs_baseline = 1'b0;
                        end else begin
                            wr_data.needs_baseline = 1'b1;
                        end
                    end
                    if (r_item.cmd == CMD_CLEAR) begin
                        n_in_use = '0;
                    end
                    n_gap_total      = r_gap_total + SUM_W'(c_gap);
                    n_reorder_total  = r_reorder_total + SUM_W'(c_reord);
                    n_out.tracked      = c_tracked;
                    n_out.was_baseline = c_base;
                    n_out.gap_added    = c_gap;
                    n_out.reordered    = c_reord;
                    n_out.gap_sum      = n_gap_total;
                    n_out.reorder_sum  = n_reorder_total;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPD) |=> ($stable(r_gap_total) && $stable(r_reorder_total)))
        else $error("totals moved outside the update step");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !r_out_valid) |=> (!r_out_valid || $past(r_state == ST_UPD)))
        else $error("result appeared without an update step");

    a_untracked_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tracked) |->
        (!r_out.was_baseline && !r_out.reordered && (r_out.gap_added == '0)))
        else $error("untracked item reported frame activity");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones({r_out.was_baseline, r_out.reordered,
                                     (r_out.gap_added != '0)}) <= 1))
        else $error("frame reported more than one outcome");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in flight");

endmodule
